FILE: src/sjec_pkg.sv
// ----------------------------------------------------------------------------
// sjec_pkg
// Types and byte constants shared by the Shift-JIS / EUC-JP stream converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sjec_pkg;

	localparam logic [7:0] EUC_SS2      = 8'h8E;
	localparam logic [7:0] SJ_LEAD1_LO  = 8'h81;
	localparam logic [7:0] SJ_LEAD1_HI  = 8'h9F;
	localparam logic [7:0] SJ_LEAD2_LO  = 8'hE0;
	localparam logic [7:0] SJ_LEAD2_HI  = 8'hEF;
	localparam logic [7:0] KANA_LO      = 8'hA1;
	localparam logic [7:0] KANA_HI      = 8'hDF;
	localparam logic [7:0] EUC_LEAD_LO  = 8'hA1;
	localparam logic [7:0] EUC_LEAD_HI  = 8'hFE;

	localparam logic [7:0] SJ_TRAIL_HI  = 8'h9F;
	localparam logic [7:0] SJ_TRAIL_GAP = 8'h7F;
	localparam logic [7:0] SJ_OFS_HI_E  = 8'hE0;
	localparam logic [7:0] SJ_OFS_LO_E  = 8'h60;
	localparam logic [7:0] SJ_OFS_HI_O  = 8'hE1;
	localparam logic [7:0] SJ_OFS_LO_O  = 8'h61;
	localparam logic [7:0] SJ_TR_ADD_HI = 8'h60;
	localparam logic [7:0] SJ_TR_ADD_LO = 8'h61;
	localparam logic [7:0] SJ_TR_ADD_EV = 8'h02;

	localparam logic [7:0] EUC_ROW_SPLIT = 8'hDF;
	localparam logic [7:0] EUC_ODD_LO    = 8'h31;
	localparam logic [7:0] EUC_ODD_HI    = 8'h71;
	localparam logic [7:0] EUC_EVEN_LO   = 8'h30;
	localparam logic [7:0] EUC_EVEN_HI   = 8'h70;
	localparam logic [7:0] EUC_TR_SPLIT  = 8'hE0;
	localparam logic [7:0] EUC_TR_SUB_HI = 8'h60;
	localparam logic [7:0] EUC_TR_SUB_LO = 8'h61;
	localparam logic [7:0] EUC_TR_SUB_EV = 8'h02;

	localparam logic DIR_SJIS_TO_EUC = 1'b0;
	localparam logic DIR_EUC_TO_SJIS = 1'b1;

	localparam int QUEUE_DEPTH = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
		logic       truncated;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} conv_out_t;

endpackage

`default_nettype wire

FILE: src/sjec_if.sv
// ----------------------------------------------------------------------------
// sjec_if
// Valid/ready channels for source bytes and converted bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjec_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, in_byte, end_of_string, input ready);
	modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface sjec_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;
	logic       truncated;

	modport source (output valid, out_byte, run_last, string_done, truncated, input ready);
	modport sink   (input valid, out_byte, run_last, string_done, truncated, output ready);
endinterface

`default_nettype wire

FILE: src/sjec_conv.sv
// ----------------------------------------------------------------------------
// sjec_conv
// Direction register, held lead byte and the pair conversion for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sjec_conv (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 take,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 eos,
	output sjec_pkg::conv_out_t       res
);

	logic       direction_q;
	logic [7:0] held_lead_q;
	logic       lead_pending_q;
	logic       kana_q;

	logic       hold;
	logic       hold_kana;
	logic [7:0] h2;
	logic [7:0] sj_a, sj_b, euc_a, euc_b;
	logic       sj_lead, kana, euc_lead;

	always_comb begin
		h2 = {held_lead_q[6:0], 1'b0};
		if (in_byte >= sjec_pkg::SJ_TRAIL_HI) begin
			sj_a = h2 - ((held_lead_q >= sjec_pkg::SJ_LEAD2_LO) ?
				sjec_pkg::SJ_OFS_HI_E : sjec_pkg::SJ_OFS_LO_E);
			sj_b = in_byte + sjec_pkg::SJ_TR_ADD_EV;
		end else begin
			sj_a = h2 - ((held_lead_q >= sjec_pkg::SJ_LEAD2_LO) ?
				sjec_pkg::SJ_OFS_HI_O : sjec_pkg::SJ_OFS_LO_O);
			sj_b = in_byte + ((in_byte >= sjec_pkg::SJ_TRAIL_GAP) ?
				sjec_pkg::SJ_TR_ADD_HI : sjec_pkg::SJ_TR_ADD_LO);
		end
		if (held_lead_q[0]) begin
			euc_a = {1'b0, held_lead_q[7:1]} + ((held_lead_q < sjec_pkg::EUC_ROW_SPLIT) ?
				sjec_pkg::EUC_ODD_LO : sjec_pkg::EUC_ODD_HI);
			euc_b = in_byte - ((in_byte >= sjec_pkg::EUC_TR_SPLIT) ?
				sjec_pkg::EUC_TR_SUB_HI : sjec_pkg::EUC_TR_SUB_LO);
		end else begin
			euc_a = {1'b0, held_lead_q[7:1]} + ((held_lead_q < sjec_pkg::EUC_ROW_SPLIT) ?
				sjec_pkg::EUC_EVEN_LO : sjec_pkg::EUC_EVEN_HI);
			euc_b = in_byte - sjec_pkg::EUC_TR_SUB_EV;
		end
	end

	assign sj_lead  = (in_byte inside {[sjec_pkg::SJ_LEAD1_LO : sjec_pkg::SJ_LEAD1_HI],
		[sjec_pkg::SJ_LEAD2_LO : sjec_pkg::SJ_LEAD2_HI]});
	assign kana     = (in_byte inside {[sjec_pkg::KANA_LO : sjec_pkg::KANA_HI]});
	assign euc_lead = (in_byte inside {[sjec_pkg::EUC_LEAD_LO : sjec_pkg::EUC_LEAD_HI]});

	always_comb begin
		hold      = 1'b0;
		hold_kana = 1'b0;
		res.count = 2'd1;
		res.r0    = '{out_byte: in_byte, run_last: 1'b1, string_done: eos, truncated: 1'b0};
		res.r1    = '{out_byte: in_byte, run_last: 1'b1, string_done: eos, truncated: 1'b0};
		if (lead_pending_q) begin
			if (direction_q == sjec_pkg::DIR_SJIS_TO_EUC) begin
				res.count       = 2'd2;
				res.r0.out_byte = sj_a;
				res.r1.out_byte = sj_b;
			end else if (!kana_q) begin
				res.count       = 2'd2;
				res.r0.out_byte = euc_a;
				res.r1.out_byte = euc_b;
			end
		end else if (direction_q == sjec_pkg::DIR_SJIS_TO_EUC) begin
			if (sj_lead) begin
				hold = !eos;
				res.r0.truncated = eos;
				if (!eos)
					res.count = 2'd0;
			end else if (kana) begin
				res.count       = 2'd2;
				res.r0.out_byte = sjec_pkg::EUC_SS2;
			end
		end else begin
			if (euc_lead || in_byte == sjec_pkg::EUC_SS2) begin
				hold      = !eos;
				hold_kana = !eos && (in_byte == sjec_pkg::EUC_SS2);
				res.r0.truncated = eos;
				if (!eos)
					res.count = 2'd0;
			end
		end
		if (res.count == 2'd2) begin
			res.r0.run_last    = 1'b0;
			res.r0.string_done = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q    <= sjec_pkg::DIR_SJIS_TO_EUC;
			held_lead_q    <= '0;
			lead_pending_q <= 1'b0;
			kana_q         <= 1'b0;
		end else if (cfg_we) begin
			direction_q    <= cfg_wdata;
			held_lead_q    <= '0;
			lead_pending_q <= 1'b0;
			kana_q         <= 1'b0;
		end else if (take) begin
			held_lead_q    <= hold ? in_byte : 8'h00;
			lead_pending_q <= hold;
			kana_q         <= hold_kana;
		end
	end

endmodule

`default_nettype wire

FILE: src/sjis_euc_stream_converter.sv
// ----------------------------------------------------------------------------
// sjis_euc_stream_converter
// Byte stream converter between Shift-JIS and EUC-JP.
// ----------------------------------------------------------------------------
// A source byte is converted in the cycle it is taken and its zero, one or two
// result bytes go into a three-entry result queue that drives the result port.
// The result port moves one byte per cycle while result ready is high. A byte
// gives two results when it completes a pair (other than an EUC-JP kana pair)
// or is a wrapped half-width kana. A new byte is taken whenever the queue holds
// at most one byte, independent of result ready. Write direction only while
// idle; a write drops any held lead byte.
`default_nettype none

module sjis_euc_stream_converter (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	sjec_item_if.sink     item,
	sjec_result_if.source result
);

	sjec_pkg::conv_out_t res;
	sjec_pkg::result_t   q_q [sjec_pkg::QUEUE_DEPTH];
	sjec_pkg::result_t   q_nxt [sjec_pkg::QUEUE_DEPTH];
	logic [1:0]          cnt_q;
	logic [1:0]          cnt_pop;
	logic [1:0]          cnt_nxt;
	logic                push, pop;

	sjec_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (push),
		.in_byte   (item.in_byte),
		.eos       (item.end_of_string),
		.res       (res)
	);

	assign item.ready = (cnt_q <= 2'd1);
	assign push       = item.valid && item.ready;
	assign pop        = result.valid && result.ready;
	assign cnt_pop    = cnt_q - {1'b0, pop};
	assign cnt_nxt    = cnt_pop + (push ? res.count : 2'd0);

	always_comb begin
		for (int i = 0; i < sjec_pkg::QUEUE_DEPTH; i++) begin
			if (pop && i < sjec_pkg::QUEUE_DEPTH - 1)
				q_nxt[i] = q_q[i + 1];
			else
				q_nxt[i] = q_q[i];
			if (push && res.count != 2'd0 && 2'(i) == cnt_pop)
				q_nxt[i] = res.r0;
			if (push && res.count == 2'd2 && 2'(i) == cnt_pop + 2'd1)
				q_nxt[i] = res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < sjec_pkg::QUEUE_DEPTH; i++)
			q_q[i] <= q_nxt[i];
	end

	assign result.valid       = (cnt_q != 2'd0);
	assign result.out_byte    = q_q[0].out_byte;
	assign result.run_last    = q_q[0].run_last;
	assign result.string_done = q_q[0].string_done;
	assign result.truncated   = q_q[0].truncated;

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + $past(res.count))
		else $error("queue count does not follow pushed results");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.string_done |-> result.run_last)
		else $error("string end flagged on a byte that is not the last of its transaction");

	a_trunc_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.truncated |-> result.string_done)
		else $error("truncated lead byte not at string end");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_pop + res.count <= 2'd3 && cnt_pop <= 2'd1)
		else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the Shift-JIS / EUC-JP stream converter.
// ----------------------------------------------------------------------------
// A short table of directed steps (boundary bytes, truncated leads, kana, a
// lead dropped by a direction change) is followed by random phases of mostly
// well-formed characters in both directions, mixed with noise and broken
// sequences. Each accepted source byte is run through a local conversion
// model; every result transaction is checked field by field, in order, against
// the bytes that the model or a typed step expects. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int SRC_BYTES    = 650;
	localparam int N_PHASES     = 6;
	localparam int SETTLE_CYC   = 4;
	localparam int DRAIN_CYC    = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_STEPS      = 27;

	typedef enum logic [1:0] {
		STEP_PREDICT,
		STEP_TYPED,
		STEP_DIR
	} step_kind_t;

	typedef struct packed {
		step_kind_t        kind;
		logic [7:0]        data;
		logic              eos;
		logic [1:0]        n_typed;
		sjec_pkg::result_t r0;
		sjec_pkg::result_t r1;
	} step_t;

	localparam step_t DIRECTED_STEPS [N_STEPS] = '{
		'{STEP_TYPED,   8'h00, 1'b0, 2'd1, '{8'h00, 1'b1, 1'b0, 1'b0}, '0},
		'{STEP_TYPED,   8'hA1, 1'b0, 2'd2, '{sjec_pkg::EUC_SS2, 1'b0, 1'b0, 1'b0},
			'{8'hA1, 1'b1, 1'b0, 1'b0}},
		'{STEP_TYPED,   8'hDF, 1'b1, 2'd2, '{sjec_pkg::EUC_SS2, 1'b0, 1'b0, 1'b0},
			'{8'hDF, 1'b1, 1'b1, 1'b0}},
		'{STEP_TYPED,   8'hFF, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b1, 1'b0}, '0},
		'{STEP_TYPED,   8'h80, 1'b0, 2'd1, '{8'h80, 1'b1, 1'b0, 1'b0}, '0},
		'{STEP_TYPED,   8'h81, 1'b1, 2'd1, '{8'h81, 1'b1, 1'b1, 1'b1}, '0},
		'{STEP_PREDICT, 8'h81, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'h40, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'h9F, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hFC, 1'b1, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hE0, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'h9F, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hEF, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'h00, 1'b1, 2'd0, '0, '0},
		// lead left waiting, then dropped by the direction write
		'{STEP_PREDICT, 8'h9F, 1'b0, 2'd0, '0, '0},
		'{STEP_DIR,     8'h01, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hA1, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hA1, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hFE, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hFE, 1'b1, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hDF, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, 8'hE0, 1'b0, 2'd0, '0, '0},
		'{STEP_PREDICT, sjec_pkg::EUC_SS2, 1'b0, 2'd0, '0, '0},
		'{STEP_TYPED,   8'hDF, 1'b1, 2'd1, '{8'hDF, 1'b1, 1'b1, 1'b0}, '0},
		'{STEP_TYPED,   sjec_pkg::EUC_SS2, 1'b1, 2'd1,
			'{sjec_pkg::EUC_SS2, 1'b1, 1'b1, 1'b1}, '0},
		'{STEP_TYPED,   8'hFE, 1'b1, 2'd1, '{8'hFE, 1'b1, 1'b1, 1'b1}, '0},
		'{STEP_DIR,     8'h00, 1'b0, 2'd0, '0, '0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	sjec_item_if   item_ch ();
	sjec_result_if result_ch ();

	sjis_euc_stream_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	// conversion model state
	logic              conv_dir;
	logic [7:0]        held_byte;
	logic              byte_held;
	logic              held_ss2;
	sjec_pkg::result_t conv_res [2];

	sjec_pkg::result_t awaited_out [$];
	int      fail_count;
	int      sent_count;
	int      taken_count;
	int      cycle_count;
	logic    src_steady;
	logic    dst_steady;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sjis_euc_stream_converter regression: fail");
			$finish;
		end
	end

	function automatic sjec_pkg::result_t make_result(input logic [7:0] b,
			input logic last, input logic done, input logic trunc);
		sjec_pkg::result_t r;
		r.out_byte    = b;
		r.run_last    = last;
		r.string_done = done;
		r.truncated   = trunc;
		return r;
	endfunction

	// Returns the number of result bytes placed in conv_res.
	function automatic int convert_byte(input logic [7:0] b, input logic eos);
		logic [7:0] h;
		logic [7:0] x;
		logic [7:0] y;
		logic       kana;
		if (byte_held) begin
			h = held_byte;
			kana = held_ss2;
			byte_held = 1'b0;
			held_ss2 = 1'b0;
			held_byte = '0;
			if (conv_dir == sjec_pkg::DIR_SJIS_TO_EUC) begin
				if (b >= sjec_pkg::SJ_TRAIL_HI) begin
					x = {h[6:0], 1'b0} - ((h >= sjec_pkg::SJ_LEAD2_LO) ?
						sjec_pkg::SJ_OFS_HI_E : sjec_pkg::SJ_OFS_LO_E);
					y = b + sjec_pkg::SJ_TR_ADD_EV;
				end else begin
					x = {h[6:0], 1'b0} - ((h >= sjec_pkg::SJ_LEAD2_LO) ?
						sjec_pkg::SJ_OFS_HI_O : sjec_pkg::SJ_OFS_LO_O);
					y = b + ((b >= sjec_pkg::SJ_TRAIL_GAP) ?
						sjec_pkg::SJ_TR_ADD_HI : sjec_pkg::SJ_TR_ADD_LO);
				end
			end else if (kana) begin
				conv_res[0] = make_result(b, 1'b1, eos, 1'b0);
				return 1;
			end else if (h[0]) begin
				x = (h >> 1) + ((h < sjec_pkg::EUC_ROW_SPLIT) ?
					sjec_pkg::EUC_ODD_LO : sjec_pkg::EUC_ODD_HI);
				y = b - ((b >= sjec_pkg::EUC_TR_SPLIT) ?
					sjec_pkg::EUC_TR_SUB_HI : sjec_pkg::EUC_TR_SUB_LO);
			end else begin
				x = (h >> 1) + ((h < sjec_pkg::EUC_ROW_SPLIT) ?
					sjec_pkg::EUC_EVEN_LO : sjec_pkg::EUC_EVEN_HI);
				y = b - sjec_pkg::EUC_TR_SUB_EV;
			end
			conv_res[0] = make_result(x, 1'b0, 1'b0, 1'b0);
			conv_res[1] = make_result(y, 1'b1, eos, 1'b0);
			return 2;
		end
		if (conv_dir == sjec_pkg::DIR_SJIS_TO_EUC) begin
			if ((b >= sjec_pkg::SJ_LEAD1_LO && b <= sjec_pkg::SJ_LEAD1_HI) ||
					(b >= sjec_pkg::SJ_LEAD2_LO && b <= sjec_pkg::SJ_LEAD2_HI)) begin
				if (eos) begin
					conv_res[0] = make_result(b, 1'b1, 1'b1, 1'b1);
					return 1;
				end
				held_byte = b;
				byte_held = 1'b1;
				return 0;
			end
			if (b >= sjec_pkg::KANA_LO && b <= sjec_pkg::KANA_HI) begin
				conv_res[0] = make_result(sjec_pkg::EUC_SS2, 1'b0, 1'b0, 1'b0);
				conv_res[1] = make_result(b, 1'b1, eos, 1'b0);
				return 2;
			end
		end else if ((b >= sjec_pkg::EUC_LEAD_LO && b <= sjec_pkg::EUC_LEAD_HI) ||
				b == sjec_pkg::EUC_SS2) begin
			if (eos) begin
				conv_res[0] = make_result(b, 1'b1, 1'b1, 1'b1);
				return 1;
			end
			held_byte = b;
			byte_held = 1'b1;
			held_ss2 = (b == sjec_pkg::EUC_SS2);
			return 0;
		end
		conv_res[0] = make_result(b, 1'b1, eos, 1'b0);
		return 1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
			input logic [1:0] n_typed, input sjec_pkg::result_t t0,
			input sjec_pkg::result_t t1);
		int gap;
		int n;
		if (sent_count % 40 == 0)
			src_steady = ($urandom_range(0, 3) == 0);
		gap = src_steady ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.in_byte       <= b;
		item_ch.end_of_string <= eos;
		do @(posedge clk); while (!item_ch.ready);
		n = convert_byte(b, eos);
		if (typed) begin
			if (n_typed > 0)
				awaited_out.push_back(t0);
			if (n_typed > 1)
				awaited_out.push_back(t1);
		end else begin
			for (int k = 0; k < n; k++)
				awaited_out.push_back(conv_res[k]);
		end
		sent_count++;
	endtask

	task automatic set_direction(input logic d);
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (awaited_out.size() != 0)
			@(negedge clk);
		// a held lead produces nothing, so give the block time to go quiet
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		conv_dir  = d;
		held_byte = '0;
		byte_held = 1'b0;
		held_ss2  = 1'b0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_plain(input logic [7:0] b, input logic eos);
		send_byte(b, eos, 1'b0, 2'd0, '0, '0);
	endtask

	// One character of the current encoding, sometimes malformed.
	task automatic send_char(input logic d);
		int         kind;
		logic [7:0] lead;
		logic [7:0] trail;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			if (d == sjec_pkg::DIR_SJIS_TO_EUC) begin
				lead = 8'(($urandom_range(0, 2) != 0) ?
					$urandom_range(sjec_pkg::SJ_LEAD1_LO, sjec_pkg::SJ_LEAD1_HI) :
					$urandom_range(sjec_pkg::SJ_LEAD2_LO, sjec_pkg::SJ_LEAD2_HI));
				trail = 8'($urandom_range(8'h40, 8'hFC));
			end else begin
				lead  = 8'($urandom_range(sjec_pkg::EUC_LEAD_LO, sjec_pkg::EUC_LEAD_HI));
				trail = 8'($urandom_range(sjec_pkg::EUC_LEAD_LO, sjec_pkg::EUC_LEAD_HI));
			end
			if ($urandom_range(0, 7) == 0)
				trail = 8'($urandom_range(0, 255));
			send_plain(lead, $urandom_range(0, 24) == 0);
			send_plain(trail, $urandom_range(0, 7) == 0);
		end else if (kind <= 5) begin
			if (d == sjec_pkg::DIR_EUC_TO_SJIS)
				send_plain(sjec_pkg::EUC_SS2, $urandom_range(0, 24) == 0);
			send_plain(8'($urandom_range(sjec_pkg::KANA_LO, sjec_pkg::KANA_HI)),
				$urandom_range(0, 7) == 0);
		end else if (kind <= 7) begin
			send_plain(8'($urandom_range(0, 8'h7F)), $urandom_range(0, 7) == 0);
		end else begin
			send_plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// result side: random stalls, in-order check
	initial begin
		int                stall;
		sjec_pkg::result_t got;
		sjec_pkg::result_t want;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken_count % 30 == 0)
				dst_steady = ($urandom_range(0, 3) == 0);
			stall = dst_steady ? 0 : $urandom_range(0, 12);
			@(negedge clk);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got = make_result(result_ch.out_byte, result_ch.run_last,
				result_ch.string_done, result_ch.truncated);
			taken_count++;
			if (awaited_out.size() == 0) begin
				$display("%0t: expected no transaction, got %h", $time, got);
				fail_count++;
			end else begin
				want = awaited_out.pop_front();
				if (got.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %h got %h", $time,
						want.out_byte, got.out_byte);
					fail_count++;
				end
				if (got.run_last !== want.run_last) begin
					$display("%0t: run_last expected %b got %b", $time,
						want.run_last, got.run_last);
					fail_count++;
				end
				if (got.string_done !== want.string_done) begin
					$display("%0t: string_done expected %b got %b", $time,
						want.string_done, got.string_done);
					fail_count++;
				end
				if (got.truncated !== want.truncated) begin
					$display("%0t: truncated expected %b got %b", $time,
						want.truncated, got.truncated);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic d;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.in_byte       = '0;
		item_ch.end_of_string = 1'b0;
		conv_dir    = sjec_pkg::DIR_SJIS_TO_EUC;
		held_byte   = '0;
		byte_held   = 1'b0;
		held_ss2    = 1'b0;
		fail_count  = 0;
		sent_count  = 0;
		taken_count = 0;
		cycle_count = 0;
		src_steady  = 1'b0;
		dst_steady  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_STEPS[i]) begin
			if (DIRECTED_STEPS[i].kind == STEP_DIR)
				set_direction(DIRECTED_STEPS[i].data[0]);
			else
				send_byte(DIRECTED_STEPS[i].data, DIRECTED_STEPS[i].eos,
					DIRECTED_STEPS[i].kind == STEP_TYPED, DIRECTED_STEPS[i].n_typed,
					DIRECTED_STEPS[i].r0, DIRECTED_STEPS[i].r1);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			d = (p % 2 == 0) ? sjec_pkg::DIR_EUC_TO_SJIS : sjec_pkg::DIR_SJIS_TO_EUC;
			set_direction(d);
			while (sent_count < N_STEPS + (p + 1) * SRC_BYTES / N_PHASES)
				send_char(d);
		end

		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (awaited_out.size() != 0)
			@(posedge clk);
		// longer than the largest result stall, so a stray transaction is seen
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0)
			$display("sjis_euc_stream_converter regression: pass");
		else
			$display("sjis_euc_stream_converter regression: fail");
		$finish;
	end

endmodule
